// ===== rtl/gne_pkg.sv =====
// ----------------------------------------------------------------------------
// gne_pkg
// Shared types and constants of the Gaussian normal extraction pipeline.
// ----------------------------------------------------------------------------
package gne_pkg;

    // Field widths
    localparam int QUAT_W   = 24;
    localparam int LSCALE_W = 16;
    localparam int NRM_W    = 16;
    localparam int PROD_W   = 2 * QUAT_W;
    localparam int NUM_W    = PROD_W + 2;
    localparam int DEN_W    = PROD_W + 1;
    localparam int EXP_IN_W = LSCALE_W + 2;

    // Exponential engine
    localparam int           EXP_TERMS  = 13;
    localparam logic [31:0]  LOG2E_Q30  = 32'd1549082005;
    localparam logic [31:0]  LN2_Q32    = 32'd2977044472;
    localparam int           SCALE_DROP = 12;
    localparam int           RATIO_DROP = 16;
    localparam int           EXP_LAT    = 3 + 3 * (EXP_TERMS - 1);

    // Normal entry divider
    localparam int Q_BITS  = 16;
    localparam int DIV_LAT = Q_BITS + 2;

    // Whole pipeline: two front stages, the exponential, one output stage
    localparam int PIPE_LAT = 2 + EXP_LAT + 1;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_ZERO_QUAT = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SCL  = 2'd2;

    typedef struct packed {
        logic signed [QUAT_W-1:0]   quat_w;
        logic signed [QUAT_W-1:0]   quat_x;
        logic signed [QUAT_W-1:0]   quat_y;
        logic signed [QUAT_W-1:0]   quat_z;
        logic signed [LSCALE_W-1:0] log_scale_a;
        logic signed [LSCALE_W-1:0] log_scale_b;
        logic signed [LSCALE_W-1:0] log_scale_c;
    } gne_in_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
        logic [15:0]             confidence;
        logic [31:0]             smallest_scale;
        logic [31:0]             middle_scale;
        logic [1:0]              status;
    } gne_out_t;

    typedef struct packed {
        logic signed [NRM_W-1:0] nx;
        logic signed [NRM_W-1:0] ny;
        logic signed [NRM_W-1:0] nz;
    } gne_vec_t;

endpackage

// ===== rtl/gne_stream_if.sv =====
// ----------------------------------------------------------------------------
// gne_stream_if
// Valid/ready stream channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface gne_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/gne_exp.sv =====
// ----------------------------------------------------------------------------
// gne_exp
// Pipelined exp of a Q6.12 value, quantised to a saturated 32-bit output.
// ----------------------------------------------------------------------------
module gne_exp
    import gne_pkg::*;
#(
    parameter int DROP = SCALE_DROP
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [EXP_IN_W-1:0] v,
    output logic [31:0]                scale
);

    localparam int NT = EXP_TERMS - 1;
    localparam logic signed [31:0] LOG2E_S = LOG2E_Q30;

    logic signed [EXP_IN_W+31:0] t_next;
    logic [31:0]                 f1_reg;
    logic signed [7:0]           k1_reg;
    logic [63:0]                 uprod;
    logic [31:0]                 u2_reg;
    logic signed [7:0]           k2_reg;

    assign t_next = v * LOG2E_S;
    assign uprod  = 64'(f1_reg) * 64'(LN2_Q32);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= t_next[41:10];
            k1_reg <= t_next[49:42];
            u2_reg <= uprod[63:32];
            k2_reg <= k1_reg;
        end
    end

    // Taylor terms: multiply by u, divide by n through a reciprocal, correct
    logic [31:0]       p_a_reg [0:NT-1];
    logic [33:0]       sum_a_reg [0:NT-1];
    logic [31:0]       u_a_reg [0:NT-1];
    logic signed [7:0] k_a_reg [0:NT-1];
    logic [31:0]       p_b_reg [0:NT-1];
    logic [31:0]       q_b_reg [0:NT-1];
    logic [33:0]       sum_b_reg [0:NT-1];
    logic [31:0]       u_b_reg [0:NT-1];
    logic signed [7:0] k_b_reg [0:NT-1];
    logic [31:0]       term_c_reg [0:NT-1];
    logic [33:0]       sum_c_reg [0:NT-1];
    logic [31:0]       u_c_reg [0:NT-1];
    logic signed [7:0] k_c_reg [0:NT-1];

    for (genvar j = 0; j < NT; j++)
    begin : g_term
        localparam int          N       = j + 2;
        localparam logic [32:0] RECIP_W = (33'd1 << 32) / N;
        localparam logic [31:0] RECIP   = RECIP_W[31:0];

        logic [31:0]       term_src;
        logic [33:0]       sum_src;
        logic [31:0]       u_src;
        logic signed [7:0] k_src;
        logic [63:0]       pprod;
        logic [63:0]       qprod;
        logic [35:0]       rem;
        logic [31:0]       term_next;

        if (j == 0)
        begin : g_first
            assign term_src = u2_reg;
            assign sum_src  = (34'd1 << 32) + 34'(u2_reg);
            assign u_src    = u2_reg;
            assign k_src    = k2_reg;
        end
        else
        begin : g_rest
            assign term_src = term_c_reg[j-1];
            assign sum_src  = sum_c_reg[j-1];
            assign u_src    = u_c_reg[j-1];
            assign k_src    = k_c_reg[j-1];
        end

        assign pprod     = 64'(term_src) * 64'(u_src);
        assign qprod     = 64'(p_a_reg[j]) * 64'(RECIP);
        assign rem       = 36'(p_b_reg[j]) - 36'(q_b_reg[j]) * 36'(N);
        assign term_next = q_b_reg[j] + ((rem >= 36'(N)) ? 32'd1 : 32'd0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_a_reg[j]    <= pprod[63:32];
                sum_a_reg[j]  <= sum_src;
                u_a_reg[j]    <= u_src;
                k_a_reg[j]    <= k_src;
                p_b_reg[j]    <= p_a_reg[j];
                q_b_reg[j]    <= qprod[63:32];
                sum_b_reg[j]  <= sum_a_reg[j];
                u_b_reg[j]    <= u_a_reg[j];
                k_b_reg[j]    <= k_a_reg[j];
                term_c_reg[j] <= term_next;
                sum_c_reg[j]  <= sum_b_reg[j] + 34'(term_next);
                u_c_reg[j]    <= u_b_reg[j];
                k_c_reg[j]    <= k_b_reg[j];
            end
        end
    end

    // Quantise mant * 2^k, rounding half up and saturating
    logic signed [9:0] sh;
    logic [40:0]       rnd;
    logic [31:0]       scale_next;
    logic [31:0]       scale_reg;

    always_comb
    begin
        sh  = 10'(DROP) - 10'(k_c_reg[NT-1]);
        rnd = '0;
        if (sh <= 10'sd0)
        begin
            scale_next = 32'hFFFF_FFFF;
        end
        else if (sh >= 10'sd40)
        begin
            scale_next = '0;
        end
        else
        begin
            rnd = (41'(sum_c_reg[NT-1]) + (41'd1 << (sh[5:0] - 6'd1))) >> sh[5:0];
            scale_next = (rnd[40:32] != '0) ? 32'hFFFF_FFFF : rnd[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scale_reg <= scale_next;
        end
    end

    assign scale = scale_reg;

endmodule

// ===== rtl/gne_div.sv =====
// ----------------------------------------------------------------------------
// gne_div
// Pipelined restoring divider: rotation entry num/den to rounded Q1.15.
// ----------------------------------------------------------------------------
module gne_div
    import gne_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic signed [NRM_W-1:0] entry
);

    localparam int REM_W = NUM_W + 15;

    logic [REM_W-1:0]  rem_reg [0:Q_BITS];
    logic [DEN_W-1:0]  den_reg [0:Q_BITS];
    logic [Q_BITS-1:0] q_reg [0:Q_BITS];
    logic              neg_reg [0:Q_BITS];

    logic [NUM_W-1:0] mag;

    assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // Take magnitude and add half the divisor for rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {mag, 15'd0} + REM_W'(den >> 1);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NUM_W-1];
        end
    end

    for (genvar i = 0; i < Q_BITS; i++)
    begin : g_bit
        localparam int B = Q_BITS - 1 - i;

        logic [REM_W-1:0] sub;
        logic             take;

        assign sub  = REM_W'(den_reg[i]) << B;
        assign take = (rem_reg[i] >= sub);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= take ? (rem_reg[i] - sub) : rem_reg[i];
                den_reg[i+1] <= den_reg[i];
                q_reg[i+1]   <= q_reg[i] | (take ? (Q_BITS'(1) << B) : '0);
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic [NRM_W-1:0] val;
    logic [NRM_W-1:0] entry_reg;

    assign val = (q_reg[Q_BITS] > Q_BITS'(32767)) ? NRM_W'(32767) : NRM_W'(q_reg[Q_BITS]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= neg_reg[Q_BITS] ? (~val + NRM_W'(1)) : val;
        end
    end

    assign entry = $signed(entry_reg);

endmodule

// ===== rtl/gaussian_normal_extract.sv =====
// ----------------------------------------------------------------------------
// gaussian_normal_extract
// Surface normal, confidence and principal scales of one Gaussian per item.
// ----------------------------------------------------------------------------
// Usage:
//   gaussian  (sink)   : one item holds an unnormalised quaternion and three
//                        log scales.
//   result    (source) : one item per input item, in order: the canonical
//                        normal, confidence, smallest and middle scale, status.
//   From acceptance to result valid, an item passes two front stages
//   (products, then sums and axis pick), the exponential engine (two
//   multiplies, three stages for each of twelve Taylor terms, one quantise
//   stage) with the 18-stage normal divider padded alongside, and one
//   output stage. One item is accepted every cycle unless the receiver stalls.
//   The whole pipeline advances together: it moves whenever the output
//   register is empty or its item is being taken. When the receiver stalls
//   with a result waiting, every stage holds; bubbles in flight keep their
//   place and nothing is lost or repeated.
//   Reset clears the valid bits of all stages; the pipeline comes up empty
//   and ready.
// ----------------------------------------------------------------------------
module gaussian_normal_extract
    import gne_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    gne_stream_if.sink   gaussian,
    gne_stream_if.source result
);

    localparam logic [1:0] AXIS_A = 2'd0;
    localparam logic [1:0] AXIS_B = 2'd1;
    localparam logic [1:0] AXIS_C = 2'd2;
    localparam int         PAD    = EXP_LAT - DIV_LAT;

    logic    en;
    gne_in_t pl;

    // Advance all stages when the output slot is free or being drained
    assign en             = !result.valid || result.ready;
    assign gaussian.ready = en;
    assign pl             = gaussian.data;

    // Valid bits travel with the data
    logic [PIPE_LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], gaussian.valid};
        end
    end

    // ---- Front stage 1: products and smallest axis --------------------------
    logic [1:0]                 axis_next;
    logic signed [LSCALE_W-1:0] lmin_next;
    logic signed [LSCALE_W-1:0] lmid_next;

    always_comb
    begin
        axis_next = AXIS_A;
        if (pl.log_scale_b < pl.log_scale_a)
        begin
            axis_next = AXIS_B;
        end
        if (pl.log_scale_c < ((axis_next == AXIS_B) ? pl.log_scale_b : pl.log_scale_a))
        begin
            axis_next = AXIS_C;
        end
        case (axis_next)
            AXIS_A:
            begin
                lmin_next = pl.log_scale_a;
                lmid_next = (pl.log_scale_b < pl.log_scale_c) ? pl.log_scale_b
                                                              : pl.log_scale_c;
            end
            AXIS_B:
            begin
                lmin_next = pl.log_scale_b;
                lmid_next = (pl.log_scale_c < pl.log_scale_a) ? pl.log_scale_c
                                                              : pl.log_scale_a;
            end
            default:
            begin
                lmin_next = pl.log_scale_c;
                lmid_next = (pl.log_scale_a < pl.log_scale_b) ? pl.log_scale_a
                                                              : pl.log_scale_b;
            end
        endcase
    end

    logic signed [PROD_W-1:0]   ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0]   xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    logic [1:0]                 axis_reg;
    logic signed [LSCALE_W-1:0] lmin_reg;
    logic signed [LSCALE_W-1:0] lmid_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg   <= pl.quat_w * pl.quat_w;
            xx_reg   <= pl.quat_x * pl.quat_x;
            yy_reg   <= pl.quat_y * pl.quat_y;
            zz_reg   <= pl.quat_z * pl.quat_z;
            xy_reg   <= pl.quat_x * pl.quat_y;
            zw_reg   <= pl.quat_z * pl.quat_w;
            xz_reg   <= pl.quat_x * pl.quat_z;
            yw_reg   <= pl.quat_y * pl.quat_w;
            yz_reg   <= pl.quat_y * pl.quat_z;
            xw_reg   <= pl.quat_x * pl.quat_w;
            axis_reg <= axis_next;
            lmin_reg <= lmin_next;
            lmid_reg <= lmid_next;
        end
    end

    // ---- Front stage 2: norm, numerators of the chosen column ---------------
    logic signed [NUM_W-1:0] sww, sxx, syy, szz, sxy, szw, sxz, syw, syz, sxw;
    logic signed [NUM_W-1:0] dsum;
    logic signed [NUM_W-1:0] n0_next, n1_next, n2_next;

    always_comb
    begin
        sww  = NUM_W'(ww_reg);
        sxx  = NUM_W'(xx_reg);
        syy  = NUM_W'(yy_reg);
        szz  = NUM_W'(zz_reg);
        sxy  = NUM_W'(xy_reg);
        szw  = NUM_W'(zw_reg);
        sxz  = NUM_W'(xz_reg);
        syw  = NUM_W'(yw_reg);
        syz  = NUM_W'(yz_reg);
        sxw  = NUM_W'(xw_reg);
        dsum = sww + sxx + syy + szz;
        case (axis_reg)
            AXIS_A:
            begin
                n0_next = sww + sxx - syy - szz;
                n1_next = (sxy + szw) <<< 1;
                n2_next = (sxz - syw) <<< 1;
            end
            AXIS_B:
            begin
                n0_next = (sxy - szw) <<< 1;
                n1_next = sww - sxx + syy - szz;
                n2_next = (syz + sxw) <<< 1;
            end
            default:
            begin
                n0_next = (sxz + syw) <<< 1;
                n1_next = (syz - sxw) <<< 1;
                n2_next = sww - sxx - syy + szz;
            end
        endcase
    end

    logic [DEN_W-1:0]           den_reg;
    logic signed [NUM_W-1:0]    n0_reg, n1_reg, n2_reg;
    logic                       dz_reg;
    logic signed [EXP_IN_W-1:0] vmin_reg, vmid_reg, vrat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= dsum[DEN_W-1:0];
            dz_reg   <= (dsum == '0);
            n0_reg   <= n0_next;
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            vmin_reg <= EXP_IN_W'(lmin_reg);
            vmid_reg <= EXP_IN_W'(lmid_reg);
            vrat_reg <= (EXP_IN_W'(lmin_reg) - EXP_IN_W'(lmid_reg)) <<< 1;
        end
    end

    // ---- Exponential engines ------------------------------------------------
    logic [31:0] smallest, middle, ratio;

    gne_exp #(.DROP(SCALE_DROP)) u_exp_min (
        .clk   (clk),
        .en    (en),
        .v     (vmin_reg),
        .scale (smallest)
    );

    gne_exp #(.DROP(SCALE_DROP)) u_exp_mid (
        .clk   (clk),
        .en    (en),
        .v     (vmid_reg),
        .scale (middle)
    );

    gne_exp #(.DROP(RATIO_DROP)) u_exp_rat (
        .clk   (clk),
        .en    (en),
        .v     (vrat_reg),
        .scale (ratio)
    );

    // ---- Normal dividers, padded to the exponential latency -----------------
    logic signed [NRM_W-1:0] div_x, div_y, div_z;

    gne_div u_div_x (.clk(clk), .en(en), .num(n0_reg), .den(den_reg), .entry(div_x));
    gne_div u_div_y (.clk(clk), .en(en), .num(n1_reg), .den(den_reg), .entry(div_y));
    gne_div u_div_z (.clk(clk), .en(en), .num(n2_reg), .den(den_reg), .entry(div_z));

    gne_vec_t pad_reg [0:PAD-1];
    logic     dz_pipe_reg [0:EXP_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pad_reg[0]     <= {div_x, div_y, div_z};
            dz_pipe_reg[0] <= dz_reg;
            for (int i = 1; i < PAD; i++)
            begin
                pad_reg[i] <= pad_reg[i-1];
            end
            for (int i = 1; i < EXP_LAT; i++)
            begin
                dz_pipe_reg[i] <= dz_pipe_reg[i-1];
            end
        end
    end

    // ---- Output stage: confidence, canonical sign, status -------------------
    gne_vec_t         nv;
    logic [15:0]      conf;
    logic [NRM_W:0]   ax, ay, az;
    logic             flip;
    gne_out_t         res_next;
    gne_out_t         res_reg;

    always_comb
    begin
        nv = pad_reg[PAD-1];

        // Drop to zero when the ratio reaches one; clamp an empty ratio
        if (ratio[31:16] != '0)
        begin
            conf = '0;
        end
        else if (ratio[15:0] == '0)
        begin
            conf = 16'hFFFF;
        end
        else
        begin
            conf = 16'(17'h1_0000 - 17'(ratio[15:0]));
        end

        ax = nv.nx[NRM_W-1] ? (NRM_W+1)'(-nv.nx) : (NRM_W+1)'(nv.nx);
        ay = nv.ny[NRM_W-1] ? (NRM_W+1)'(-nv.ny) : (NRM_W+1)'(nv.ny);
        az = nv.nz[NRM_W-1] ? (NRM_W+1)'(-nv.nz) : (NRM_W+1)'(nv.nz);

        // Major component: first largest magnitude
        if (az > ((ay > ax) ? ay : ax))
        begin
            flip = nv.nz[NRM_W-1];
        end
        else if (ay > ax)
        begin
            flip = nv.ny[NRM_W-1];
        end
        else
        begin
            flip = nv.nx[NRM_W-1];
        end

        res_next = '0;
        if (dz_pipe_reg[EXP_LAT-1])
        begin
            res_next.status = STATUS_ZERO_QUAT;
        end
        else if (smallest == '0 || middle == '0)
        begin
            res_next.status = STATUS_ZERO_SCL;
        end
        else
        begin
            res_next.status         = STATUS_OK;
            res_next.confidence     = conf;
            res_next.smallest_scale = smallest;
            res_next.middle_scale   = middle;
            if (conf != '0)
            begin
                res_next.normal_x = flip ? -nv.nx : nv.nx;
                res_next.normal_y = flip ? -nv.ny : nv.ny;
                res_next.normal_z = flip ? -nv.nz : nv.nz;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid = vld_reg[PIPE_LAT-1];
    assign result.data  = res_reg;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gaussian_normal_extract. It predicts each result
// from the quaternion and log scales (axis pick, rotation column, Taylor
// exponential, confidence, sign canonicalisation) and checks every result
// item in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb
    import gne_pkg::*;
();

    localparam int           HALF_PERIOD = 6;
    localparam int           RESET_CYCLES = 6;
    localparam int           IDLE_LIMIT = 4000;
    localparam int           LONG_HOLD = 240;
    localparam int           RANDOM_ITEMS = 326;
    localparam int           MAX_REPORTS = 10;
    localparam longint       LOG2E_FIX = 1549082005;
    localparam longint unsigned LN2_FIX = 64'd2977044472;
    localparam int           SERIES_LEN = 13;
    localparam int           Q1_15_MAX = 32767;
    localparam longint unsigned SCALE_SAT = 64'hFFFF_FFFF;

    logic clk;
    logic rst_n;

    gne_stream_if #(.payload_t(gne_in_t))  gaussian_ch ();
    gne_stream_if #(.payload_t(gne_out_t)) result_ch ();

    gaussian_normal_extract dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .gaussian (gaussian_ch),
        .result   (result_ch)
    );

    // Expected result items, oldest first
    gne_out_t pending_results[$];

    int  mismatches;
    int  items_sent;
    int  results_seen;
    int  conf_zero_seen;
    int  zero_quat_seen;
    int  idle_cycles;
    int  rx_cycle;
    int  hold_left;
    bit  long_hold;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // exp(v / 4096) as a Q32 mantissa in [1, 2) and a power of two
    function automatic void exp_split(input longint v, output longint unsigned mant,
                                      output int pow2);
        longint          t;
        longint unsigned tb_bits;
        longint unsigned frac;
        longint unsigned u;
        longint unsigned term;
        longint unsigned sum;
        t       = v * LOG2E_FIX;
        tb_bits = longint'(t + (longint'(64) <<< 42));
        frac    = (tb_bits & ((64'd1 << 42) - 64'd1)) >> 10;
        u       = (frac * LN2_FIX) >> 32;
        term    = 64'd1 << 32;
        sum     = 64'd1 << 32;
        for (int n = 1; n <= SERIES_LEN; n++)
        begin
            term = (term * u) >> 32;
            term = term / longint'(n);
            sum  = sum + term;
        end
        mant = sum;
        pow2 = int'(tb_bits >> 42) - 64;
    endfunction

    // Round half up to the fixed-point grid and saturate at 32 bits
    function automatic longint unsigned quantise(longint unsigned mant, int pow2, int drop);
        int              sh;
        longint unsigned r;
        sh = drop - pow2;
        if (sh <= 0)
            return SCALE_SAT;
        if (sh >= 40)
            return 0;
        r = (mant + (64'd1 << (sh - 1))) >> sh;
        return (r > SCALE_SAT) ? SCALE_SAT : r;
    endfunction

    function automatic longint unsigned exp_fixed(longint v, int drop);
        longint unsigned mant;
        int              pow2;
        exp_split(v, mant, pow2);
        return quantise(mant, pow2, drop);
    endfunction

    // Numerator over norm squared, to Q1.15, rounding half away from zero
    function automatic int ratio_q15(longint num, longint unsigned den);
        longint unsigned mag;
        longint unsigned val;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        val = ((mag << 15) + den / 2) / den;
        if (val > Q1_15_MAX)
            val = Q1_15_MAX;
        return (num < 0) ? -int'(val) : int'(val);
    endfunction

    function automatic gne_out_t predict_normal(gne_in_t g);
        gne_out_t        res;
        longint          w, x, y, z;
        longint          lg[3];
        longint          num[3];
        longint          lmin, lmid;
        longint unsigned norm_sq, smallest, middle, ratio_sq, conf;
        int              nrm[3];
        int              axis, major, ma, mb;
        w = g.quat_w;
        x = g.quat_x;
        y = g.quat_y;
        z = g.quat_z;
        lg[0] = g.log_scale_a;
        lg[1] = g.log_scale_b;
        lg[2] = g.log_scale_c;
        res = '0;
        norm_sq = w * w + x * x + y * y + z * z;
        if (norm_sq == 0)
        begin
            res.status = STATUS_ZERO_QUAT;
            return res;
        end
        axis = 0;
        for (int a = 1; a < 3; a++)
            if (lg[a] < lg[axis])
                axis = a;
        lmin = lg[axis];
        lmid = (lg[(axis + 1) % 3] < lg[(axis + 2) % 3]) ? lg[(axis + 1) % 3]
                                                        : lg[(axis + 2) % 3];
        smallest = exp_fixed(lmin, SCALE_DROP);
        middle   = exp_fixed(lmid, SCALE_DROP);
        if (smallest == 0 || middle == 0)
        begin
            res.status = STATUS_ZERO_SCL;
            return res;
        end
        ratio_sq = exp_fixed(2 * (lmin - lmid), RATIO_DROP);
        conf = (ratio_sq >= 65536) ? 0 : 65536 - ratio_sq;
        if (conf > 65535)
            conf = 65535;
        case (axis)
            0:
            begin
                num[0] = w * w + x * x - y * y - z * z;
                num[1] = 2 * (x * y + z * w);
                num[2] = 2 * (x * z - y * w);
            end
            1:
            begin
                num[0] = 2 * (x * y - z * w);
                num[1] = w * w - x * x + y * y - z * z;
                num[2] = 2 * (y * z + x * w);
            end
            default:
            begin
                num[0] = 2 * (x * z + y * w);
                num[1] = 2 * (y * z - x * w);
                num[2] = w * w - x * x - y * y + z * z;
            end
        endcase
        for (int a = 0; a < 3; a++)
            nrm[a] = ratio_q15(num[a], norm_sq);
        // Largest magnitude wins, the first one on ties
        major = 0;
        for (int a = 1; a < 3; a++)
        begin
            ma = (nrm[a] < 0) ? -nrm[a] : nrm[a];
            mb = (nrm[major] < 0) ? -nrm[major] : nrm[major];
            if (ma > mb)
                major = a;
        end
        if (nrm[major] < 0)
            for (int a = 0; a < 3; a++)
                nrm[a] = -nrm[a];
        if (conf == 0)
            nrm = '{0, 0, 0};
        res.normal_x       = nrm[0][15:0];
        res.normal_y       = nrm[1][15:0];
        res.normal_z       = nrm[2][15:0];
        res.confidence     = conf[15:0];
        res.smallest_scale = smallest[31:0];
        res.middle_scale   = middle[31:0];
        res.status         = STATUS_OK;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: compare every accepted result item with the oldest
    // expectation, field by field
    // ------------------------------------------------------------------------
    task automatic flag(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("tb: mismatch on %s at result %0d: expected %0h, got %0h",
                     what, results_seen, want, got);
    endtask

    always @(posedge clk)
    begin
        gne_out_t want;
        gne_out_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (pending_results.size() == 0)
                flag("unexpected result", 0, got.status);
            else
            begin
                want = pending_results.pop_front();
                if (got.normal_x !== want.normal_x)
                    flag("normal_x", want.normal_x, got.normal_x);
                if (got.normal_y !== want.normal_y)
                    flag("normal_y", want.normal_y, got.normal_y);
                if (got.normal_z !== want.normal_z)
                    flag("normal_z", want.normal_z, got.normal_z);
                if (got.confidence !== want.confidence)
                    flag("confidence", want.confidence, got.confidence);
                if (got.smallest_scale !== want.smallest_scale)
                    flag("smallest_scale", want.smallest_scale, got.smallest_scale);
                if (got.middle_scale !== want.middle_scale)
                    flag("middle_scale", want.middle_scale, got.middle_scale);
                if (got.status !== want.status)
                    flag("status", want.status, got.status);
                if (want.status == STATUS_OK && want.confidence == 0)
                    conf_zero_seen++;
                if (want.status == STATUS_ZERO_QUAT)
                    zero_quat_seen++;
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: cycle through always-ready, random and patterned stalls;
    // on request, hold off for a long stretch counted here
    // ------------------------------------------------------------------------
    initial
    begin
        result_ch.ready = 1'b0;
        rx_cycle = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_cycle++;
            if (long_hold && hold_left == 0)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    long_hold = 1'b0;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle >> 6) % 4)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 1) == 1);
                    2: result_ch.ready <= (rx_cycle % 5 != 0);
                    default: result_ch.ready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing is accepted for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((gaussian_ch.valid && gaussian_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("tb: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender helpers
    // ------------------------------------------------------------------------

    // Offer one item from the falling edge and hold it until accepted
    task automatic send_gaussian(gne_in_t g);
        @(negedge clk);
        gaussian_ch.valid <= 1'b1;
        gaussian_ch.data  <= g;
        @(posedge clk);
        while (!gaussian_ch.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_normal(g));
        items_sent++;
    endtask

    task automatic idle_sender(int cycles);
        @(negedge clk);
        gaussian_ch.valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Pause until every expected result has come back
    task automatic wait_drained();
        idle_sender(0);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic gne_in_t make_gaussian(longint w, longint x, longint y, longint z,
                                              longint a, longint b, longint c);
        gne_in_t g;
        g.quat_w      = w[23:0];
        g.quat_x      = x[23:0];
        g.quat_y      = y[23:0];
        g.quat_z      = z[23:0];
        g.log_scale_a = a[15:0];
        g.log_scale_b = b[15:0];
        g.log_scale_c = c[15:0];
        return g;
    endfunction

    // Random item: mostly moderate quaternions and close log scales, so that
    // the confidence and sign logic see varied values; some raw bit noise
    function automatic gne_in_t random_gaussian();
        gne_in_t g;
        int      kind;
        int      base;
        kind = $urandom_range(0, 99);
        g = $bits(gne_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if (kind < 60)
        begin
            g.quat_w = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
            g.quat_x = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
            g.quat_y = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
            g.quat_z = $signed(24'($urandom_range(0, 262143))) - 24'sd131072;
            base = $urandom_range(0, 40000) - 20000;
            g.log_scale_a = 16'(base + $urandom_range(0, 6000) - 3000);
            g.log_scale_b = 16'(base + $urandom_range(0, 6000) - 3000);
            g.log_scale_c = 16'(base + $urandom_range(0, 6000) - 3000);
        end
        else if (kind < 66)
        begin
            g.log_scale_b = g.log_scale_a;
            if (kind < 63)
                g.log_scale_c = g.log_scale_a;
        end
        else if (kind < 69)
        begin
            g.quat_w = '0;
            g.quat_x = '0;
            g.quat_y = '0;
            g.quat_z = '0;
        end
        else if (kind < 75)
        begin
            // Nearly axis-aligned rotation: one part dominates
            g.quat_x = 24'($signed(g.quat_x) >>> 12);
            g.quat_y = 24'($signed(g.quat_y) >>> 12);
            g.quat_z = 24'($signed(g.quat_z) >>> 12);
        end
        return g;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Field extremes, zero quaternion, largest and tiny scales
    task automatic test_field_extremes();
        send_gaussian(make_gaussian(0, 0, 0, 0, 0, 1, 2));
        send_gaussian(make_gaussian(0, 0, 0, 0, -32768, 32767, 0));
        send_gaussian(make_gaussian(8388607, 8388607, 8388607, 8388607, 0, 4096, 8192));
        send_gaussian(make_gaussian(-8388608, -8388608, -8388608, -8388608, 0, 4096, 8192));
        send_gaussian(make_gaussian(8388607, -8388608, 1, -1, -32768, 32767, 32767));
        send_gaussian(make_gaussian(65536, 0, 0, 0, 32767, 32767, 32767));
        send_gaussian(make_gaussian(65536, 0, 0, 0, -32768, -32768, -32768));
        send_gaussian(make_gaussian(1, 0, 0, 0, 32766, 32767, -32768));
        send_gaussian(make_gaussian(0, 0, 0, -1, -32768, -32767, 32767));
        wait_drained();
    endtask

    // Each axis, ties among the log scales, canonical sign, zero confidence
    task automatic test_axis_and_ties();
        send_gaussian(make_gaussian(65536, 0, 0, 0, -4096, 0, 4096));
        send_gaussian(make_gaussian(65536, 0, 0, 0, 0, -4096, 4096));
        send_gaussian(make_gaussian(65536, 0, 0, 0, 0, 4096, -4096));
        send_gaussian(make_gaussian(65536, 0, 0, 0, -100, -100, 0));
        send_gaussian(make_gaussian(65536, 0, 0, 0, 0, -100, -100));
        send_gaussian(make_gaussian(65536, 0, 0, 0, -200, 50, 50));
        send_gaussian(make_gaussian(65536, 0, 0, 0, 1234, 1234, 1234));
        // A half turn about x points the y column downwards: flip it up
        send_gaussian(make_gaussian(0, 65536, 0, 0, 0, -4096, 4096));
        send_gaussian(make_gaussian(0, 0, 65536, 0, -4096, 0, 4096));
        // Equal-magnitude parts: ties between normal components
        send_gaussian(make_gaussian(65536, 65536, 65536, 65536, 0, 100, 200));
        send_gaussian(make_gaussian(-65536, 65536, -65536, 65536, 300, 100, 200));
        send_gaussian(make_gaussian(46341, 46341, 0, 0, 300, 200, 100));
        send_gaussian(make_gaussian(3, -7, 11, -5, -1, 0, 0));
        wait_drained();
    endtask

    // Bursts of random length with random gaps
    task automatic test_random_stream(int count);
        int left;
        int burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst) send_gaussian(random_gaussian());
            left -= burst;
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 6));
        end
    endtask

    // Long receiver hold-off while items keep coming: the pipeline fills and
    // the input stalls
    task automatic test_backpressure_fill();
        long_hold = 1'b1;
        repeat (PIPE_LAT + 60) send_gaussian(random_gaussian());
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        gaussian_ch.valid = 1'b0;
        gaussian_ch.data  = '0;
        rst_n = 1'b0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        conf_zero_seen = 0;
        zero_quat_seen = 0;
        idle_cycles = 0;
        long_hold = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_field_extremes();
        test_axis_and_ties();
        test_random_stream(RANDOM_ITEMS / 2);
        test_backpressure_fill();
        test_random_stream(RANDOM_ITEMS / 2);

        wait_drained();
        repeat (PIPE_LAT + 10) @(posedge clk);
        if (pending_results.size() != 0)
            flag("missing results", 0, pending_results.size());

        $display("tb: %0d items in, %0d results checked, %0d mismatches",
                 items_sent, results_seen, mismatches);
        $display("tb: %0d zero-confidence and %0d zero-quaternion results, one long stall",
                 conf_zero_seen, zero_quat_seen);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== gaussian_normal_extract.f =====
rtl/gne_pkg.sv
rtl/gne_stream_if.sv
rtl/gne_exp.sv
rtl/gne_div.sv
rtl/gaussian_normal_extract.sv
verif/tb.sv
